[rtl/core/psstore_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the positional sequence store.
// Holds the opcode and status codes and the controller/datapath interface types.
// No dependencies.
package psstore_pkg;

    // Operation codes carried with each request.
    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_POS   = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_DEL_POS   = 3'd5;
    localparam logic [2:0] OP_DUMP      = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cmd;    // capture the incoming request
        logic exec;        // apply a single-result operation and load its result
        logic dump_start;  // clear the dump counter
        logic dump_step;   // emit the front word and rotate the sequence
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dump_go;     // held request is a dump of a non-empty store
        logic dump_last;   // the next dump word is the final one
    } t_dp_status;

endpackage

[rtl/core/psstore_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the positional sequence store: request holding flag, result
// slot flag and the dump sequencer. Depends on psstore_pkg.
module psstore_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    input  psstore_pkg::t_dp_status i_status,
    output psstore_pkg::t_dp_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic                 r_cmd_full;
    logic                 n_cmd_full;
    logic                 r_out_full;
    logic                 n_out_full;
    logic                 out_free;
    logic                 s_ready;
    psstore_pkg::t_dp_cmd cmd;

    // Next-state and command decode.
    always_comb begin
        out_free   = !r_out_full || i_m_tready;
        cmd        = '0;
        n_state    = r_state;
        n_cmd_full = r_cmd_full;
        n_out_full = r_out_full && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                if (r_cmd_full && out_free) begin
                    if (i_status.dump_go) begin
                        cmd.dump_start = 1'b1;
                        n_state        = S_DUMP;
                    end else begin
                        cmd.exec   = 1'b1;
                        n_out_full = 1'b1;
                        n_cmd_full = 1'b0;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    cmd.dump_step = 1'b1;
                    n_out_full    = 1'b1;
                    if (i_status.dump_last) begin
                        n_state    = S_IDLE;
                        n_cmd_full = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // A new request may enter as soon as the held one completes, never during reset.
        s_ready      = i_rst_n && (!r_cmd_full || cmd.exec);
        cmd.load_cmd = i_s_tvalid && s_ready;
        if (cmd.load_cmd) begin
            n_cmd_full = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cmd_full <= 1'b0;
            r_out_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmd_full <= n_cmd_full;
            r_out_full <= n_out_full;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_full;
    assign o_cmd      = cmd;

endmodule

[rtl/core/psstore_dp.sv]
`timescale 1ns / 1ps
// Datapath of the positional sequence store: request register, the row of
// shifting cells, the fill count, the dump counter and the result register.
// Depends on psstore_pkg.
module psstore_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  psstore_pkg::t_dp_cmd    i_cmd,
    output psstore_pkg::t_dp_status o_status,
    input  logic [2:0]              i_opcode,
    input  logic signed [31:0]      i_value,
    input  logic [4:0]              i_position,
    output logic [1:0]              o_status_code,
    output logic [4:0]              o_element_count,
    output logic [31:0]             o_element,
    output logic                    o_element_valid,
    output logic                    o_last
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = ((CW > 5) ? CW : 5) + 1;
    localparam int EXW  = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

    logic [2:0]            r_cmd_op;
    logic signed [31:0]    r_cmd_value;
    logic [4:0]            r_cmd_pos;
    logic [DATA_WIDTH-1:0] r_cells [DEPTH];
    logic [DATA_WIDTH-1:0] n_cells [DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [CW-1:0]         r_dump_idx;

    logic [1:0]            r_out_status;
    logic [4:0]            r_out_count;
    logic [31:0]           r_out_elem;
    logic                  r_out_ev;
    logic                  r_out_last;

    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CMPW-1:0]       cntn_w;
    logic [CMPW-1:0]       k_w;
    logic [IW-1:0]         k;
    logic                  is_full;
    logic                  is_empty;
    logic                  do_ins;
    logic                  do_del;
    logic [1:0]            st;
    logic [EXW-1:0]        word_ext;
    logic [DATA_WIDTH-1:0] word;
    logic [EXW-1:0]        elem_ext;
    logic                  dump_last;

    // Request register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cmd) begin
            r_cmd_op    <= i_opcode;
            r_cmd_value <= i_value;
            r_cmd_pos   <= i_position;
        end
    end

    // Operation decode and checks against the fill count.
    always_comb begin
        pos_w    = CMPW'(r_cmd_pos);
        cnt_w    = CMPW'(r_count);
        is_full  = (cnt_w == CMPW'(DEPTH));
        is_empty = (r_count == '0);
        do_ins   = 1'b0;
        do_del   = 1'b0;
        st       = psstore_pkg::ST_OK;
        k_w      = '0;
        case (r_cmd_op)
            psstore_pkg::OP_INS_FRONT: begin
                if (is_full) st = psstore_pkg::ST_FULL;
                else         do_ins = 1'b1;
            end
            psstore_pkg::OP_INS_BACK: begin
                k_w = cnt_w;
                if (is_full) st = psstore_pkg::ST_FULL;
                else         do_ins = 1'b1;
            end
            psstore_pkg::OP_INS_POS: begin
                k_w = pos_w - 1'b1;
                if (is_full) begin
                    st = psstore_pkg::ST_FULL;
                end else if (pos_w == '0 || pos_w > cnt_w + 1'b1) begin
                    st = psstore_pkg::ST_BADPOS;
                end else begin
                    do_ins = 1'b1;
                end
            end
            psstore_pkg::OP_DEL_FRONT: begin
                if (is_empty) st = psstore_pkg::ST_EMPTY;
                else          do_del = 1'b1;
            end
            psstore_pkg::OP_DEL_BACK: begin
                k_w = cnt_w - 1'b1;
                if (is_empty) st = psstore_pkg::ST_EMPTY;
                else          do_del = 1'b1;
            end
            psstore_pkg::OP_DEL_POS: begin
                k_w = pos_w - 1'b1;
                if (is_empty) begin
                    st = psstore_pkg::ST_EMPTY;
                end else if (pos_w == '0 || pos_w > cnt_w) begin
                    st = psstore_pkg::ST_BADPOS;
                end else begin
                    do_del = 1'b1;
                end
            end
            default: begin
                st = psstore_pkg::ST_OK;
            end
        endcase
        k = k_w[IW-1:0];
    end

    // The stored word is the request value sign-extended or cut to the cell width.
    assign word_ext = EXW'(r_cmd_value);
    assign word     = word_ext[DATA_WIDTH-1:0];

    // Each cell picks its neighbour, the new word or itself.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            if (i_cmd.exec && do_ins) begin
                if (IW'(i) == k) begin
                    n_cells[i] = word;
                end else if (i > 0 && IW'(i) > k) begin
                    n_cells[i] = r_cells[(i > 0) ? i - 1 : 0];
                end
            end else if (i_cmd.exec && do_del) begin
                if (i < DEPTH - 1 && IW'(i) >= k) begin
                    n_cells[i] = r_cells[(i < DEPTH - 1) ? i + 1 : i];
                end
            end else if (i_cmd.dump_step) begin
                // Rotate the live words so the front always holds the next one out.
                if (CW'(i + 1) < r_count) begin
                    n_cells[i] = r_cells[(i < DEPTH - 1) ? i + 1 : i];
                end else if (CW'(i + 1) == r_count) begin
                    n_cells[i] = r_cells[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
    end

    // Fill count and dump counter.
    always_comb begin
        n_count = r_count;
        if (i_cmd.exec && do_ins) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.exec && do_del) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_dump_idx <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.dump_start) begin
                r_dump_idx <= '0;
            end else if (i_cmd.dump_step) begin
                r_dump_idx <= r_dump_idx + 1'b1;
            end
        end
    end

    assign dump_last = (CW'(r_dump_idx + 1'b1) == r_count);
    assign cntn_w    = CMPW'(n_count);
    assign elem_ext  = EXW'(r_cells[0]);

    // Result register, loaded by a single-result operation or by a dump step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= st;
            r_out_count  <= cntn_w[4:0];
            r_out_elem   <= '0;
            r_out_ev     <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.dump_step) begin
            r_out_status <= psstore_pkg::ST_OK;
            r_out_count  <= cnt_w[4:0];
            r_out_elem   <= elem_ext[31:0];
            r_out_ev     <= 1'b1;
            r_out_last   <= dump_last;
        end
    end

    assign o_status.dump_go   = (r_cmd_op == psstore_pkg::OP_DUMP) && !is_empty;
    assign o_status.dump_last = dump_last;
    assign o_status_code      = r_out_status;
    assign o_element_count    = r_out_count;
    assign o_element          = r_out_elem;
    assign o_element_valid    = r_out_ev;
    assign o_last             = r_out_last;

endmodule

[rtl/core/positional_sequence_store.sv]
`timescale 1ns / 1ps
// Positional sequence store: an ordered list of up to DEPTH words with
// positional insert and delete and a dump of the whole list.
// Channels: requests enter on the s_axis group (tuser = opcode, tdata = value
// and 1-based position); results leave on the m_axis group with tlast marking
// the final result of each request. Every request but a dump of a non-empty
// list yields one result carrying status and element count; such a dump yields
// one result per stored word, front first, with element_valid set.
// Flow: an accepted request waits in the request register until the result
// register is free, then executes and loads its result onto the master side.
// Insert and delete shift every cell in parallel, so one request per cycle is
// sustained while the receiver keeps up. A dump holds the request register
// while it runs: first the sequencer starts, then one word a cycle follows while
// the receiver keeps up, set by the single rotating read of the front cell.
// A stalled receiver holds the result register; one further request is taken
// into the request register and waits there.
// Reset clears the count, the dump sequencer and both valid flags, and holds
// the request side not ready; the cells themselves are not cleared and only
// live entries are ever read.
// Depends on psstore_pkg, psstore_ctrl and psstore_dp.
module positional_sequence_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [2:0]  i_s_axis_tuser,   // opcode[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // element_count[4:0], element[36:5], zero pad
    output logic [2:0]  o_m_axis_tuser,   // status[1:0], element_valid[2]
    output logic        o_m_axis_tlast
);

    psstore_pkg::t_dp_cmd    w_cmd;
    psstore_pkg::t_dp_status w_status;
    logic [1:0]              w_status_code;
    logic [4:0]              w_count;
    logic [31:0]             w_element;
    logic                    w_element_valid;
    logic                    w_last;

    // Handshake control and dump sequencing.
    psstore_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Storage, operation checks and result register.
    psstore_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_opcode        (i_s_axis_tuser),
        .i_value         (i_s_axis_tdata[31:0]),
        .i_position      (i_s_axis_tdata[36:32]),
        .o_status_code   (w_status_code),
        .o_element_count (w_count),
        .o_element       (w_element),
        .o_element_valid (w_element_valid),
        .o_last          (w_last)
    );

    // Result packing.
    assign o_m_axis_tdata = {3'b000, w_element, w_count};
    assign o_m_axis_tuser = {w_element_valid, w_status_code};
    assign o_m_axis_tlast = w_last;

`ifndef SYNTH
    // A dumped word always reports success.
    a_dump_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2]) |-> (o_m_axis_tuser[1:0] == psstore_pkg::ST_OK))
        else $error("dumped word carries a non-ok status");

    // Any result that is not a dumped word is the only result of its request.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[2]) |-> o_m_axis_tlast)
        else $error("single result without last");

    // No new request is taken while a dump is streaming out.
    a_dump_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.dump_step |-> !o_s_axis_tready)
        else $error("request accepted during dump");
`endif

endmodule
